@@ rtl/srcm_pkg.sv @@
// Shared types, codes and constants of the step response cost meter.
// No dependencies; used by every module in rtl/.
package srcm_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned TICK_W           = 12;
  localparam int unsigned WEIGHT_W         = 16;
  localparam int unsigned COST_W           = 63;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [COST_W-1:0]   COST_MAX       = {COST_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_ERR_RST = 16'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_EFF_RST = 16'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RIS_RST = 16'd0;
  localparam logic [TICK_W-1:0]   LOW_TICKS_RST  = 12'd500;
  localparam logic [TICK_W-1:0]   HIGH_TICKS_RST = 12'd2000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LEVEL = 3'd0,
    REG_W_ERROR    = 3'd1,
    REG_W_EFFORT   = 3'd2,
    REG_W_RISE     = 3'd3,
    REG_LOW_TICKS  = 3'd4,
    REG_HIGH_TICKS = 3'd5
  } cfg_idx_e;

  // accumulator command from the sequencer
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctrl_t;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/srcm_mul.sv @@
// Shared multiplier with a registered product.
// Depends on srcm_pkg.
module srcm_mul
  import srcm_pkg::*;
#(
  parameter int unsigned OPA_W = 33,
  parameter int unsigned OPB_W = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [OPA_W-1:0]       a_i,
  input  logic [OPB_W-1:0]       b_i,
  output logic [OPA_W+OPB_W-1:0] p_o
);

  logic [OPA_W+OPB_W-1:0] p_q, p_d;

  assign p_d = {{OPB_W{1'b0}}, a_i} * {{OPA_W{1'b0}}, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/srcm_acc.sv @@
// Saturating cost accumulator, clamps at the largest 63-bit value.
// Depends on srcm_pkg.
module srcm_acc
  import srcm_pkg::*;
#(
  parameter int unsigned PROD_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_ctrl_t         ctrl_i,
  input  logic [PROD_W-1:0] prod_i,
  output logic [COST_W-1:0] acc_o
);

  localparam int unsigned SUM_W = max_u(PROD_W, COST_W) + 1;

  logic [COST_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0]  sum;

  assign sum = SUM_W'(acc_q) + SUM_W'(prod_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = (sum >= SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/step_response_cost_meter.sv @@
// Step response cost meter: top level with config registers, sequencer and output word.
// Depends on srcm_pkg, srcm_mul and srcm_acc.
//
// One input word is one control tick. A start request taken in idle or done opens the low
// phase (drive zero for low_ticks ticks), then the high phase drives step_level for
// high_ticks ticks while the cost sum and the rise time are taken; the last high tick adds
// weight_rise*rise_ticks and reports done. Every input word gives one output word. Idle,
// low and done words skip the multiplier; in the high phase one shared multiplier forms
// the squared error, its weighted value, the squared current, its weighted value and the
// rise term in turn, and each weighted value and the rise term feeds the saturating
// accumulator the cycle after. A finished word waits in the output register; the block
// takes the next input only once that register is free to load again. Configuration is
// written through cfg_we_i / cfg_idx_i / cfg_data_i.
module step_response_cost_meter
  import srcm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                       cfg_idx_i,
  input  logic [max_u(SAMPLE_WIDTH, WEIGHT_W)-1:0]   cfg_data_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       start_req_i,
  input  logic signed [SAMPLE_WIDTH-1:0]             sensed_current_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]             drive_setpoint_o,
  output logic [1:0]                                 phase_o,
  output logic [TICK_W-1:0]                          rise_ticks_o,
  output logic                                       risen_o,
  output logic [COST_W-1:0]                          cost_o,
  output logic                                       done_res_o
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned MAG_W  = SW + 1;
  localparam int unsigned OPA_W  = 2 * SW + 1;
  localparam int unsigned OPB_W  = max_u(SW + 1, WEIGHT_W);
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQE  = 8'b0000_0010,
    S_WE   = 8'b0000_0100,
    S_SQF  = 8'b0000_1000,
    S_WF   = 8'b0001_0000,
    S_RISE = 8'b0010_0000,
    S_ADDR = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  // configuration registers
  logic signed [SW-1:0] step_q;
  logic [WEIGHT_W-1:0]  w_err_q, w_eff_q, w_rise_q;
  logic [TICK_W-1:0]    low_ticks_q, high_ticks_q;

  // test state
  state_e              state_q, state_d;
  phase_e              ph_q, ph_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [TICK_W-1:0]   rise_q, rise_d;
  logic                risen_q, risen_d;
  logic                last_q, last_d;
  logic                ovalid_q, ovalid_d;

  // word under work
  logic signed [SW-1:0] samp_q, samp_d;
  logic signed [SW-1:0] res_drive_q, res_drive_d;
  phase_e               res_ph_q, res_ph_d;
  logic                 res_done_q, res_done_d;

  // output word
  logic signed [SW-1:0] odrive_q;
  phase_e               oph_q;
  logic [TICK_W-1:0]    orise_q;
  logic                 orisen_q;
  logic [COST_W-1:0]    ocost_q;
  logic                 odone_q;
  logic                 oload;

  // shared unit interface
  logic                 mul_en;
  logic [OPA_W-1:0]     mul_a;
  logic [OPB_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;
  acc_ctrl_t            acc_ctrl;
  logic [COST_W-1:0]    cost_acc;

  logic signed [MAG_W-1:0] diff, samp_x;
  logic [MAG_W-1:0]        diff_mag, samp_mag;
  logic                    start_ok;
  phase_e                  ph_eff;
  logic [TICK_W-1:0]       tick_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      w_err_q      <= WEIGHT_ERR_RST;
      w_eff_q      <= WEIGHT_EFF_RST;
      w_rise_q     <= WEIGHT_RIS_RST;
      low_ticks_q  <= LOW_TICKS_RST;
      high_ticks_q <= HIGH_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_LEVEL: step_q       <= $signed(cfg_data_i[SW-1:0]);
        REG_W_ERROR:    w_err_q      <= cfg_data_i[WEIGHT_W-1:0];
        REG_W_EFFORT:   w_eff_q      <= cfg_data_i[WEIGHT_W-1:0];
        REG_W_RISE:     w_rise_q     <= cfg_data_i[WEIGHT_W-1:0];
        REG_LOW_TICKS:  low_ticks_q  <= cfg_data_i[TICK_W-1:0];
        REG_HIGH_TICKS: high_ticks_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign diff     = MAG_W'(sensed_current_i) - MAG_W'(step_q);
  assign diff_mag = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
  assign samp_x   = MAG_W'(samp_q);
  assign samp_mag = samp_x[MAG_W-1] ? (~samp_x + 1'b1) : samp_x;

  assign start_ok = start_req_i && ((ph_q == PH_IDLE) || (ph_q == PH_DONE));
  assign ph_eff   = start_ok ? PH_LOW : ph_q;
  assign tick_inc = (start_ok ? '0 : tick_q) + 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign oload      = (state_q == S_OUT) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    tick_d      = tick_q;
    rise_d      = rise_q;
    risen_d     = risen_q;
    last_d      = last_q;
    samp_d      = samp_q;
    res_drive_d = res_drive_q;
    res_ph_d    = res_ph_q;
    res_done_d  = res_done_q;
    ovalid_d    = ovalid_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    acc_ctrl    = '0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          samp_d      = sensed_current_i;
          res_drive_d = '0;
          res_ph_d    = ph_eff;
          res_done_d  = 1'b0;
          ph_d        = ph_eff;
          state_d     = S_OUT;
          if (start_ok) begin
            rise_d       = '0;
            risen_d      = 1'b0;
            acc_ctrl.clr = 1'b1;
          end
          priority if (ph_eff == PH_LOW) begin
            if (tick_inc >= low_ticks_q) begin
              ph_d   = PH_HIGH;
              tick_d = '0;
            end else begin
              tick_d = tick_inc;
            end
          end else if (ph_eff == PH_HIGH) begin
            res_drive_d = step_q;
            if (!risen_q && (sensed_current_i >= step_q)) begin
              risen_d = 1'b1;
              rise_d  = tick_q;
            end
            tick_d  = tick_inc;
            last_d  = (tick_inc >= high_ticks_q);
            // square the tracking error first
            mul_en  = 1'b1;
            mul_a   = OPA_W'(diff_mag);
            mul_b   = OPB_W'(diff_mag);
            state_d = S_SQE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SQE: begin
        mul_en  = 1'b1;
        mul_a   = prod[OPA_W-1:0];
        mul_b   = OPB_W'(w_err_q);
        state_d = S_WE;
      end
      S_WE: begin
        acc_ctrl.add = 1'b1;
        mul_en       = 1'b1;
        mul_a        = OPA_W'(samp_mag);
        mul_b        = OPB_W'(samp_mag);
        state_d      = S_SQF;
      end
      S_SQF: begin
        mul_en  = 1'b1;
        mul_a   = prod[OPA_W-1:0];
        mul_b   = OPB_W'(w_eff_q);
        state_d = S_WF;
      end
      S_WF: begin
        acc_ctrl.add = 1'b1;
        state_d      = last_q ? S_RISE : S_OUT;
      end
      S_RISE: begin
        mul_en  = 1'b1;
        mul_a   = OPA_W'(rise_q);
        mul_b   = OPB_W'(w_rise_q);
        state_d = S_ADDR;
      end
      S_ADDR: begin
        acc_ctrl.add = 1'b1;
        ph_d         = PH_DONE;
        res_ph_d     = PH_DONE;
        res_done_d   = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (oload) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= PH_IDLE;
      tick_q   <= '0;
      rise_q   <= '0;
      risen_q  <= 1'b0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      tick_q   <= tick_d;
      rise_q   <= rise_d;
      risen_q  <= risen_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q      <= samp_d;
    res_drive_q <= res_drive_d;
    res_ph_q    <= res_ph_d;
    res_done_q  <= res_done_d;
    if (oload) begin
      odrive_q <= res_drive_q;
      oph_q    <= res_ph_q;
      orise_q  <= rise_q;
      orisen_q <= risen_q;
      ocost_q  <= cost_acc;
      odone_q  <= res_done_q;
    end
  end

  srcm_mul #(
    .OPA_W(OPA_W),
    .OPB_W(OPB_W)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  srcm_acc #(
    .PROD_W(PROD_W)
  ) u_acc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(acc_ctrl),
    .prod_i(prod),
    .acc_o (cost_acc)
  );

  assign out_valid_o      = ovalid_q;
  assign drive_setpoint_o = odrive_q;
  assign phase_o          = oph_q;
  assign rise_ticks_o     = orise_q;
  assign risen_o          = orisen_q;
  assign cost_o           = ocost_q;
  assign done_res_o       = odone_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start the sequencer");

  a_rise_needs_risen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !risen_q |-> (rise_q == '0))
    else $error("rise time captured without rise flag");

  a_done_word_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (phase_o == PH_DONE))
    else $error("done word without done phase");

endmodule
